// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the rank transform.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define VRT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rank transform: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define VRT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rank transform: next-cycle check failed");

`endif

// ===== rtl/vrt_pkg.sv =====
// Shared types and constants for the value rank transform.
// No dependencies; used by vrt_cell and value_rank_transform.
package vrt_pkg;

    localparam int KEY_W  = 32;
    localparam int CNT_W  = 7;
    localparam int RANK_W = 6;

    localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

    // Token moving down the chain: an arriving value and its running count
    // of stored values that are less than or equal to it.
    typedef struct packed {
        logic             v;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] acc;
    } t_tok;

    // Stored cell contents handed toward the head during result readout.
    typedef struct packed {
        logic             v;
        logic [CNT_W-1:0] count;
    } t_slot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/vrt_cell.sv =====
// One cell of the rank chain: holds one value and its count of list values
// less than or equal to it. Depends on vrt_pkg.
module vrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vrt_pkg::t_tok  i_tok,
    input  logic           i_shift,
    input  vrt_pkg::t_slot i_next,
    output vrt_pkg::t_tok  o_tok,
    output vrt_pkg::t_slot o_slot
);
    import vrt_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic             r_tok_v;
    logic [KEY_W-1:0] r_tok_key;
    logic [CNT_W-1:0] r_tok_acc;

    logic tok_le_cell;
    logic cell_le_tok;

    assign tok_le_cell = (i_tok.key <= r_key);
    assign cell_le_tok = (r_key <= i_tok.key);

    // Control: valid bit and token valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok_v <= 1'b0;
        end else begin
            r_tok_v <= i_tok.v & r_valid & ~i_shift;
            if (i_shift) begin
                r_valid <= i_next.v;
            end else if (i_tok.v) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Payload: store, count, pass the token on.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_count <= i_next.count;
        end else if (i_tok.v) begin
            if (!r_valid) begin
                r_key   <= i_tok.key;
                r_count <= i_tok.acc + CNT_W'(1);
            end else if (tok_le_cell) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
        r_tok_key <= i_tok.key;
        r_tok_acc <= i_tok.acc + CNT_W'(cell_le_tok);
    end

    assign o_tok  = '{v: r_tok_v, key: r_tok_key, acc: r_tok_acc};
    assign o_slot = '{v: r_valid, count: r_count};

endmodule

// ===== rtl/value_rank_transform.sv =====
// Top level of the value rank transform: entry control, cell chain and
// result readout. Depends on vrt_pkg and vrt_cell.
//
// Usage: present a list of signed values one per transaction on i_value with
// i_last_in high on the final one; a transaction is taken when start is high
// and busy is low. While a list is loading, busy stays low and one value is
// taken every cycle. Each value enters a chain of MAX_LEN cells and travels
// one cell per cycle, counting the stored values less than or equal to it
// and bumping the counts of those greater than or equal to it, until it
// settles in the first empty cell. Values past MAX_LEN are dropped and flag
// overflow for the whole list. After the last value is taken, busy rises.
// The chain drains until every token has settled, then the results stream
// out one per cycle in input order on o_rank with o_valid high, o_last_out
// marking the final one. Results are strobed for exactly one cycle; the
// receiver cannot stall, so no skid storage is needed. Busy falls after the
// final result.
// Reset (synchronous, active low) empties the chain and returns to idle.
module value_rank_transform #(
    parameter int MAX_LEN = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         i_value,
    input  logic                       i_last_in,
    output logic                       o_valid,
    output logic [vrt_pkg::RANK_W-1:0] o_rank,
    output logic                       o_last_out,
    output logic                       o_overflow
);
    import vrt_pkg::*;

    localparam int FILL_W = $clog2(MAX_LEN + 1);

    t_state            r_state, n_state;
    logic [FILL_W-1:0] r_fill,  n_fill;
    logic [FILL_W-1:0] r_left,  n_left;
    logic              r_drop,  n_drop;

    logic  accept;
    logic  admit;
    logic  shift;
    logic  tok_busy;
    t_tok  w_tok_in  [MAX_LEN];
    t_tok  w_tok_out [MAX_LEN];
    t_slot w_slot    [MAX_LEN];
    t_slot w_next    [MAX_LEN];

    assign busy   = (r_state != ST_IDLE);
    assign accept = start & ~busy;
    assign admit  = (r_fill < FILL_W'(MAX_LEN));
    assign shift  = (r_state == ST_EMIT);

    // Entry token: flip the sign bit so unsigned compares order signed values.
    assign w_tok_in[0] = '{v:   accept & admit,
                           key: KEY_W'(i_value) ^ SIGN_FLIP,
                           acc: '0};

    genvar g;
    generate
        for (g = 0; g < MAX_LEN; g++) begin : g_chain
            if (g > 0) begin : g_link
                assign w_tok_in[g] = w_tok_out[g-1];
            end
            if (g < MAX_LEN - 1) begin : g_feed
                assign w_next[g] = w_slot[g+1];
            end else begin : g_tail
                assign w_next[g] = '0;
            end
            vrt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok_in[g]),
                .i_shift (shift),
                .i_next  (w_next[g]),
                .o_tok   (w_tok_out[g]),
                .o_slot  (w_slot[g])
            );
        end
    endgenerate

    // Any token still walking the chain holds off readout.
    always_comb begin
        tok_busy = 1'b0;
        for (int i = 0; i < MAX_LEN; i++) begin
            tok_busy = tok_busy | w_tok_out[i].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_left  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_drop  <= n_drop;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_left  = r_left;
        n_drop  = r_drop;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (admit) begin
                        n_fill = r_fill + FILL_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_in) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // Hold until every token has settled, then start readout.
                if (!tok_busy) begin
                    n_left = r_fill;
                    if (r_fill == '0) begin
                        n_state = ST_IDLE;
                        n_drop  = 1'b0;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // Advance one result per cycle; clear list state after the last.
                n_left = r_left - FILL_W'(1);
                if (r_left == FILL_W'(1)) begin
                    n_state = ST_IDLE;
                    n_fill  = '0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Results come straight from the head cell while the chain shifts.
    assign o_valid    = shift;
    assign o_rank     = RANK_W'(w_slot[0].count - CNT_W'(1));
    assign o_last_out = shift & (r_left == FILL_W'(1));
    assign o_overflow = r_drop;

endmodule

// ===== rtl/vrt_checker.sv =====
// Port-level checks for value_rank_transform, attached by bind.
// Depends on assert_macros.svh and the top level's port names.
`include "assert_macros.svh"

module vrt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_last_in,
    input logic       o_valid,
    input logic       o_last_out,
    input logic       o_overflow
);
    `VRT_ASSERT_NOW(a_result_while_busy, i_clk, i_rst_n, o_valid, busy)
    `VRT_ASSERT_NEXT(a_last_sets_busy, i_clk, i_rst_n, start && !busy && i_last_in, busy)
    `VRT_ASSERT_NEXT(a_idle_after_final, i_clk, i_rst_n, o_valid && o_last_out, !busy)
    `VRT_ASSERT_NEXT(a_burst_steady, i_clk, i_rst_n, o_valid && !o_last_out, o_valid && $stable(o_overflow))
endmodule

bind value_rank_transform vrt_checker u_vrt_checker (.*);
